// ===== design/fsp_pkg.sv =====
// Shared constants, types and helper functions for the Fibonacci sphere point block.
package fsp_pkg;

  localparam int unsigned MAX_POINTS = 4096;
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned N_W        = 13;
  localparam int unsigned M_W        = 12;
  localparam int unsigned COORD_W    = 16;

  localparam logic [31:0] GOLDEN_TURNS = 32'h61C8_8647;
  localparam int unsigned CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam int unsigned CORDIC_STEPS = 30;

  localparam int unsigned YDIV_STEPS = 16;
  localparam int unsigned RDIV_STEPS = 49;
  localparam int unsigned SQRT_STEPS = 25;
  localparam int unsigned RADIUS_LAT = RDIV_STEPS + SQRT_STEPS;
  localparam int unsigned CORDIC_LAT = CORDIC_STEPS + 1;

  localparam int unsigned PROD_W  = 60;
  localparam int unsigned SCALE_SH = 54 - FRAC_BITS;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef logic signed [CW-1:0] cw_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      index_error;
  } res_t;

  // Q54 product to FRAC_BITS fraction bits, magnitude rounded half up, clamped to one.
  function automatic logic signed [COORD_W-1:0] scale_product(logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic [COORD_W-1:0] m16;
    begin
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      rnd = (mag + (PROD_W'(1) << (SCALE_SH - 1))) >> SCALE_SH;
      if (rnd > (PROD_W'(1) << FRAC_BITS)) begin
        m16 = COORD_W'(1) << FRAC_BITS;
      end else begin
        m16 = rnd[COORD_W-1:0];
      end
      scale_product = p[PROD_W-1] ? -$signed(m16) : $signed(m16);
    end
  endfunction

endpackage

// ===== design/fsp_if.sv =====
// Valid/ready channel interfaces for lattice indices and lattice vectors.
interface fsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [fsp_pkg::M_W-1:0]     point_index;

  modport source (output valid, output point_index, input ready);
  modport sink   (input valid, input point_index, output ready);
endinterface

interface fsp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fsp_pkg::COORD_W-1:0]  coord_x;
  logic signed [fsp_pkg::COORD_W-1:0]  coord_y;
  logic signed [fsp_pkg::COORD_W-1:0]  coord_z;
  logic                                index_error;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  output index_error, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  input index_error, output ready);
endinterface

// ===== design/fsp_delay.sv =====
// Enabled shift line that aligns one data path with a longer one.
module fsp_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) tap_q[i] <= '0;
    end else if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ===== design/fsp_height_div.sv =====
// Pipelined restoring divider for the lattice height, one quotient bit per stage.
module fsp_height_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [28:0]                        num_i,
  input  logic [13:0]                        den_i,
  output logic signed [fsp_pkg::COORD_W-1:0] y_o
);

  localparam int unsigned S = fsp_pkg::YDIV_STEPS;

  logic [13:0] rem  [S+1];
  logic [15:0] quo  [S+1];
  logic [15:0] low  [S+1];
  logic [13:0] den  [S+1];
  logic [16:0] y_full;

  assign rem[0] = {1'b0, num_i[28:16]};
  assign quo[0] = '0;
  assign low[0] = num_i[15:0];
  assign den[0] = den_i;

  for (genvar i = 0; i < S; i++) begin : g_step
    logic [14:0] trial;
    logic        ge;
    logic [14:0] diff;
    assign trial = {rem[i], low[i][15]};
    assign ge    = trial >= {1'b0, den[i]};
    assign diff  = trial - {1'b0, den[i]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[i+1] <= ge ? diff[13:0] : trial[13:0];
        quo[i+1] <= {quo[i][14:0], ge};
        low[i+1] <= {low[i][14:0], 1'b0};
        den[i+1] <= den[i];
      end
    end
  end

  // quotient is at most 2^15, so the offset result always stays within one
  assign y_full = {1'b0, quo[S]} - (17'd1 << fsp_pkg::FRAC_BITS);
  assign y_o    = $signed(y_full[fsp_pkg::COORD_W-1:0]);

endmodule

// ===== design/fsp_radius.sv =====
// Pipelined radius: 49-bit quotient P*2^48/N^2, then a digit-by-digit square root.
module fsp_radius (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [24:0] p_i,
  input  logic [24:0] d_i,
  output logic [24:0] r_o
);

  localparam int unsigned DS = fsp_pkg::RDIV_STEPS;
  localparam int unsigned SS = fsp_pkg::SQRT_STEPS;

  logic [24:0] rem  [DS+1];
  logic [48:0] quo  [DS+1];
  logic [24:0] dv   [DS+1];

  logic [49:0] val  [SS+1];
  logic [25:0] srem [SS+1];
  logic [24:0] root [SS+1];

  assign rem[0] = p_i;
  assign quo[0] = '0;
  assign dv[0]  = d_i;

  for (genvar j = 0; j < DS; j++) begin : g_div
    logic [25:0] trial;
    logic        ge;
    logic [25:0] diff;
    if (j == 0) begin : g_first
      assign trial = {1'b0, rem[j]};
    end else begin : g_next
      assign trial = {rem[j], 1'b0};
    end
    assign ge   = trial >= {1'b0, dv[j]};
    assign diff = trial - {1'b0, dv[j]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem[j+1] <= ge ? diff[24:0] : trial[24:0];
        quo[j+1] <= {quo[j][47:0], ge};
        dv[j+1]  <= dv[j];
      end
    end
  end

  assign val[0]  = {1'b0, quo[DS]};
  assign srem[0] = '0;
  assign root[0] = '0;

  for (genvar k = 0; k < SS; k++) begin : g_sqrt
    logic [27:0] cur;
    logic [27:0] trial;
    logic        ge;
    logic [27:0] diff;
    assign cur   = {srem[k], val[k][49:48]};
    assign trial = {1'b0, root[k], 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem[k+1] <= ge ? diff[25:0] : cur[25:0];
        root[k+1] <= {root[k][23:0], ge};
        val[k+1]  <= {val[k][47:0], 2'b00};
      end
    end
  end

  assign r_o = root[SS];

endmodule

// ===== design/fsp_cordic.sv =====
// Pipelined rotation CORDIC: quadrant fold, thirty micro-rotations, quadrant unfold.
module fsp_cordic (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [31:0]       a_i,
  output fsp_pkg::cw_t      cos_o,
  output fsp_pkg::cw_t      sin_o
);

  localparam int unsigned S = fsp_pkg::CORDIC_STEPS;

  fsp_pkg::cw_t cx   [S+1];
  fsp_pkg::cw_t sy   [S+1];
  fsp_pkg::cw_t zr   [S+1];
  logic [1:0]   quad [S+1];

  logic [31:0] a_off;
  logic [1:0]  q_in;
  logic [31:0] dr;

  assign a_off = a_i + 32'h2000_0000;
  assign q_in  = a_off[31:30];
  assign dr    = a_i - {q_in, 30'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx[0]   <= fsp_pkg::CORDIC_GAIN;
      sy[0]   <= '0;
      zr[0]   <= fsp_pkg::CW'($signed(dr));
      quad[0] <= q_in;
    end
  end

  for (genvar i = 0; i < S; i++) begin : g_rot
    fsp_pkg::cw_t xs, ys, at;
    assign xs = cx[i] >>> i;
    assign ys = sy[i] >>> i;
    assign at = fsp_pkg::CW'(fsp_pkg::ATAN_TURNS[i]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zr[i][fsp_pkg::CW-1]) begin
          cx[i+1] <= cx[i] - ys;
          sy[i+1] <= sy[i] + xs;
          zr[i+1] <= zr[i] - at;
        end else begin
          cx[i+1] <= cx[i] + ys;
          sy[i+1] <= sy[i] - xs;
          zr[i+1] <= zr[i] + at;
        end
        quad[i+1] <= quad[i];
      end
    end
  end

  always_comb begin
    case (quad[S])
      2'd0: begin cos_o = cx[S];  sin_o = sy[S];  end
      2'd1: begin cos_o = -sy[S]; sin_o = cx[S];  end
      2'd2: begin cos_o = -cx[S]; sin_o = -sy[S]; end
      default: begin cos_o = sy[S]; sin_o = -cx[S]; end
    endcase
  end

endmodule

// ===== design/fibonacci_sphere_point_top.sv =====
// Top level of the Fibonacci sphere lattice point generator.
// Usage: write the lattice size N on cfg_we_i/cfg_wdata_i while the block is idle
// (reset value 64, sizes above 4096 act as 4096, zero makes every index invalid).
// Send point indices on point_in; each transaction returns one unit vector on
// vec_out as signed Q2.14 x, y, z plus index_error. An index not below N gives
// index_error set and a zero vector.
// Throughput: one transaction per cycle while vec_out keeps accepting, with independent indices.
// Path: from acceptance a result passes two operand stages, the 49-stage radius
// divider and the 25-stage square root, then the product, rounding and output
// registers before vec_out; the height divider and the CORDIC run alongside and
// are delayed to match.
// Stalls: the whole pipeline advances on one enable. An output register plus a skid
// register take results, so input is still taken while a result waits; once the
// skid register fills, point_in.ready drops and every stage holds.
// Reset: asynchronous, active low; clears all valid bits, empties both output
// registers and sets N back to 64. No clearing pass is needed.
module fibonacci_sphere_point_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [fsp_pkg::N_W-1:0]  cfg_wdata_i,
  fsp_in_if.sink                   point_in,
  fsp_out_if.source                vec_out
);

  localparam int unsigned LAT = fsp_pkg::RADIUS_LAT;

  logic [fsp_pkg::N_W-1:0] num_points_q;
  logic [fsp_pkg::N_W-1:0] n_sat;

  // Pipeline enable: hold everything once the skid register is occupied.
  logic en;
  logic skid_v_q;
  assign en = !skid_v_q;
  assign point_in.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= fsp_pkg::N_W'(64);
    end else if (cfg_we_i) begin
      num_points_q <= cfg_wdata_i;
    end
  end

  assign n_sat = (num_points_q > fsp_pkg::N_W'(fsp_pkg::MAX_POINTS)) ?
                 fsp_pkg::N_W'(fsp_pkg::MAX_POINTS) : num_points_q;

  // Stage A: range check, odd numerator and azimuth step count.
  logic                    v_a_q, err_a_q;
  logic [fsp_pkg::N_W-1:0] n_a_q, odd_a_q;
  logic [fsp_pkg::M_W-1:0] k_a_q;
  logic [fsp_pkg::N_W-1:0] m_ext, m_inc;

  assign m_ext = {1'b0, point_in.point_index};
  assign m_inc = m_ext + fsp_pkg::N_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
    end else if (en) begin
      v_a_q <= point_in.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_a_q <= m_ext >= n_sat;
      n_a_q   <= n_sat;
      odd_a_q <= {point_in.point_index, 1'b1};
      // (m+1) mod N, with m below N the wrap happens only at the last point
      k_a_q   <= (m_inc == n_sat) ? '0 : m_inc[fsp_pkg::M_W-1:0];
    end
  end

  // Stage B: the three products and the height division operands.
  logic        v_b_q, err_b_q;
  logic [24:0] p_b_q, d_b_q;
  logic [31:0] a_b_q;
  logic [28:0] numy_b_q;
  logic [13:0] deny_b_q;
  logic [13:0] twon, diff_n;
  logic [26:0] p_full;
  logic [25:0] d_full;
  logic [43:0] ka_full;

  assign twon    = {n_a_q, 1'b0};
  assign diff_n  = twon - {1'b0, odd_a_q};
  assign p_full  = 27'(odd_a_q) * 27'(diff_n);
  assign d_full  = 26'(n_a_q) * 26'(n_a_q);
  assign ka_full = 44'(k_a_q) * 44'(fsp_pkg::GOLDEN_TURNS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_b_q <= 1'b0;
    end else if (en) begin
      v_b_q <= v_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_b_q  <= err_a_q;
      p_b_q    <= p_full[24:0];
      d_b_q    <= d_full[24:0];
      a_b_q    <= ka_full[31:0];
      numy_b_q <= {1'b0, odd_a_q, 15'd0} + 29'(n_a_q);
      deny_b_q <= twon;
    end
  end

  // Parallel units, all aligned to the radius path.
  logic [24:0]                        r24;
  fsp_pkg::cw_t                       cos_c, sin_c, cos_l, sin_l;
  logic signed [fsp_pkg::COORD_W-1:0] y_h, y_l;
  logic [1:0]                         ve_l;

  fsp_radius u_radius (
    .clk_i (clk_i),
    .en_i  (en),
    .p_i   (p_b_q),
    .d_i   (d_b_q),
    .r_o   (r24)
  );

  fsp_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (a_b_q),
    .cos_o (cos_c),
    .sin_o (sin_c)
  );

  fsp_height_div u_height (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numy_b_q),
    .den_i (deny_b_q),
    .y_o   (y_h)
  );

  fsp_delay #(.WIDTH(2 * fsp_pkg::CW), .DEPTH(LAT - fsp_pkg::CORDIC_LAT)) u_dly_cs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    ({cos_c, sin_c}),
    .q_o    ({cos_l, sin_l})
  );

  fsp_delay #(.WIDTH(fsp_pkg::COORD_W), .DEPTH(LAT - fsp_pkg::YDIV_STEPS)) u_dly_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    (y_h),
    .q_o    (y_l)
  );

  // Valid bit and range error travel with the radius path.
  fsp_delay #(.WIDTH(2), .DEPTH(LAT)) u_dly_ve (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .d_i    ({v_b_q, err_b_q}),
    .q_o    (ve_l)
  );

  // Product stage: scale cosine and sine by the radius.
  logic                                v_p_q, err_p_q;
  logic signed [fsp_pkg::PROD_W-1:0]   px_q, pz_q;
  logic signed [fsp_pkg::COORD_W-1:0]  y_p_q;
  logic signed [25:0]                  r_s;

  assign r_s = $signed({1'b0, r24});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p_q <= 1'b0;
    end else if (en) begin
      v_p_q <= ve_l[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_p_q <= ve_l[0];
      px_q    <= fsp_pkg::PROD_W'(cos_l) * fsp_pkg::PROD_W'(r_s);
      pz_q    <= fsp_pkg::PROD_W'(sin_l) * fsp_pkg::PROD_W'(r_s);
      y_p_q   <= y_l;
    end
  end

  // Round stage: reduce to Q2.14 and zero the vector on a range error.
  logic          v_r_q;
  fsp_pkg::res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_r_q <= 1'b0;
    end else if (en) begin
      v_r_q <= v_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q.index_error <= err_p_q;
      res_q.coord_x     <= err_p_q ? '0 : fsp_pkg::scale_product(px_q);
      res_q.coord_y     <= err_p_q ? '0 : y_p_q;
      res_q.coord_z     <= err_p_q ? '0 : fsp_pkg::scale_product(pz_q);
    end
  end

  // Output register with skid register behind it.
  logic          out_v_q;
  fsp_pkg::res_t out_q, skid_q;
  logic          push;

  assign push = en && v_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || vec_out.ready) begin
      out_v_q  <= skid_v_q || push;
      skid_v_q <= 1'b0;
    end else if (push) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || vec_out.ready) begin
      out_q <= skid_v_q ? skid_q : res_q;
    end else if (push) begin
      skid_q <= res_q;
    end
  end

  assign vec_out.valid       = out_v_q;
  assign vec_out.coord_x     = out_q.coord_x;
  assign vec_out.coord_y     = out_q.coord_y;
  assign vec_out.coord_z     = out_q.coord_z;
  assign vec_out.index_error = out_q.index_error;

  // Skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full with output register empty");

  // A stalled output with a result arriving must fill the skid register.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !vec_out.ready && push) |=> skid_v_q)
    else $error("result dropped during output stall");

  // Range errors carry a zero vector.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.index_error) |->
      (out_q.coord_x == '0 && out_q.coord_y == '0 && out_q.coord_z == '0))
    else $error("index error with non-zero vector");

  // Every component stays within one.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |->
      (out_q.coord_x <= 16'sd16384 && out_q.coord_x >= -16'sd16384 &&
       out_q.coord_y <= 16'sd16384 && out_q.coord_y >= -16'sd16384 &&
       out_q.coord_z <= 16'sd16384 && out_q.coord_z >= -16'sd16384))
    else $error("vector component outside unit range");

endmodule
